// ===== rtl/iiwv_pkg.sv =====
// ----------------------------------------------------------------------------
// iiwv_pkg: shared types and constants for the integral image block
// Field widths, the back end state type and width helpers used by all modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iiwv_pkg;

    localparam int PIXEL_W       = 8;
    localparam int INTEGRAL_W    = 18;
    localparam int SQUARE_W      = 26;
    localparam int DEVIATION_W   = 17;

    localparam int PIXEL_MAX     = 255;
    localparam int SQUARE_MAX    = 65025;

    localparam logic [DEVIATION_W-1:0] DEVIATION_MAX  = 17'h1FFFF;
    // reported when the window is flat
    localparam logic [DEVIATION_W-1:0] DEVIATION_FLAT = 17'd1;

    typedef enum logic [4:0] {
        B_TAKE = 5'b00001,
        B_MUL  = 5'b00010,
        B_DIFF = 5'b00100,
        B_ROOT = 5'b01000,
        B_OUT  = 5'b10000
    } back_state_t;

    function automatic int sum_width(int count, int peak);
        return $clog2(count * peak + 1);
    endfunction

    function automatic int max_width(int a, int b);
        return (a > b) ? a : b;
    endfunction

    function automatic int integral_width(int w, int h);
        return max_width(INTEGRAL_W, sum_width(w * h, PIXEL_MAX));
    endfunction

    function automatic int square_width(int w, int h);
        return max_width(SQUARE_W, sum_width(w * h, SQUARE_MAX));
    endfunction

    // queue entry: {last, adj_q, adj_s, sii, ii}
    function automatic int entry_width(int w, int h);
        return 1 + 2 * integral_width(w, h) + 2 * square_width(w, h);
    endfunction

endpackage

// ===== rtl/integral_image_window_variance_top.sv =====
// ----------------------------------------------------------------------------
// integral_image_window_variance_top: integral image with window deviation
// Each pixel result is registered in the queue, then in the output register.
// The frame's last pixel waits for the root unit, which forms RTW root bits
// (none for a flat window); RTW is half the radicand width (18 for a 24 x 24
// window). Throughput: one pixel per cycle while m_ready is high, with one root
// computation per frame that a 4-entry queue partly hides. Synchronous reset
// (active low) clears positions, sums, queue and control, not the line stores.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module integral_image_window_variance_top #(
    parameter int WINDOW_WIDTH  = 24,
    parameter int WINDOW_HEIGHT = 24
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [iiwv_pkg::PIXEL_W-1:0]     s_pixel,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [iiwv_pkg::INTEGRAL_W-1:0]  m_integral,
    output logic [iiwv_pkg::SQUARE_W-1:0]    m_square_integral,
    output logic                            m_deviation_valid,
    output logic [iiwv_pkg::DEVIATION_W-1:0] m_deviation
);
    import iiwv_pkg::*;

    localparam int EW          = entry_width(WINDOW_WIDTH, WINDOW_HEIGHT);
    localparam int QUEUE_DEPTH = 4;

    logic          f_valid, f_ready;
    logic [EW-1:0] f_data;
    logic          b_valid, b_ready;
    logic [EW-1:0] b_data;

    iiwv_front #(
        .WINDOW_WIDTH  (WINDOW_WIDTH),
        .WINDOW_HEIGHT (WINDOW_HEIGHT)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_pixel (s_pixel),
        .q_valid (f_valid),
        .q_ready (f_ready),
        .q_data  (f_data)
    );

    iiwv_queue #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_data)
    );

    iiwv_back #(
        .WINDOW_WIDTH  (WINDOW_WIDTH),
        .WINDOW_HEIGHT (WINDOW_HEIGHT)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .q_valid           (b_valid),
        .q_ready           (b_ready),
        .q_data            (b_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_integral        (m_integral),
        .m_square_integral (m_square_integral),
        .m_deviation_valid (m_deviation_valid),
        .m_deviation       (m_deviation)
    );

endmodule

// ===== rtl/iiwv_queue.sv =====
// ----------------------------------------------------------------------------
// iiwv_queue: small synchronous queue
// Register-based queue that decouples the pixel front end from the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iiwv_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    import iiwv_pkg::*;

    localparam int AW = max_width(1, $clog2(DEPTH));
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != COUNT_FULL);
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== rtl/iiwv_front.sv =====
// ----------------------------------------------------------------------------
// iiwv_front: pixel front end
// Tracks the frame position, builds integral and square integral values from
// row sums and line stores, and tags the last pixel with its corner terms.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iiwv_front #(
    parameter int WINDOW_WIDTH  = 24,
    parameter int WINDOW_HEIGHT = 24
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [iiwv_pkg::PIXEL_W-1:0] s_pixel,
    output logic                        q_valid,
    input  logic                        q_ready,
    output logic [iiwv_pkg::entry_width(WINDOW_WIDTH, WINDOW_HEIGHT)-1:0] q_data
);
    import iiwv_pkg::*;

    localparam int XW  = max_width(1, $clog2(WINDOW_WIDTH));
    localparam int YW  = max_width(1, $clog2(WINDOW_HEIGHT));
    localparam int IW  = integral_width(WINDOW_WIDTH, WINDOW_HEIGHT);
    localparam int QW  = square_width(WINDOW_WIDTH, WINDOW_HEIGHT);
    localparam int RSW = sum_width(WINDOW_WIDTH, PIXEL_MAX);
    localparam int RQW = sum_width(WINDOW_WIDTH, SQUARE_MAX);
    localparam int CSW = max_width(RSW, sum_width(WINDOW_HEIGHT, PIXEL_MAX));
    localparam int CQW = max_width(RQW, sum_width(WINDOW_HEIGHT, SQUARE_MAX));
    localparam logic [XW-1:0] X_LAST = XW'(WINDOW_WIDTH - 1);
    localparam logic [YW-1:0] Y_LAST = YW'(WINDOW_HEIGHT - 1);

    logic [XW-1:0]  x_reg, x_next;
    logic [YW-1:0]  y_reg, y_next;
    logic [RSW-1:0] rs_reg, rs_next;
    logic [RQW-1:0] rq_reg, rq_next;
    logic [CSW-1:0] c0_reg, c1_reg, c2_reg;
    logic [CQW-1:0] cq0_reg, cq1_reg, cq2_reg;
    logic [IW-1:0]  ii_mem [WINDOW_WIDTH];
    logic [QW-1:0]  sq_mem [WINDOW_WIDTH];
    logic [IW-1:0]  rd_ii_reg;
    logic [QW-1:0]  rd_sq_reg;

    logic                accept;
    logic [2*PIXEL_W-1:0] pp;
    logic                x_first, y_first, x_end, y_end;
    logic [IW-1:0]       ii, adj_s;
    logic [QW-1:0]       sii, adj_q;

    assign s_ready = q_ready;
    assign q_valid = s_valid;
    assign accept  = s_valid && s_ready;

    assign pp      = (2*PIXEL_W)'(s_pixel) * (2*PIXEL_W)'(s_pixel);
    assign x_first = (x_reg == '0);
    assign y_first = (y_reg == '0);
    assign x_end   = (x_reg == X_LAST);
    assign y_end   = (y_reg == Y_LAST);

    always_comb begin
        x_next = x_end ? '0 : x_reg + 1'b1;
        y_next = y_reg;
        if (x_end) begin
            y_next = y_end ? '0 : y_reg + 1'b1;
        end
    end

    // a new row restarts the running sums
    assign rs_next = (x_first ? '0 : rs_reg) + RSW'(s_pixel);
    assign rq_next = (x_first ? '0 : rq_reg) + RQW'(pp);

    assign ii  = IW'(rs_next) + (y_first ? '0 : rd_ii_reg);
    assign sii = QW'(rq_next) + (y_first ? '0 : rd_sq_reg);

    // corners are stable by the last pixel; wraps cancel in the back end
    assign adj_s = IW'(c0_reg) - IW'(c1_reg) - IW'(c2_reg);
    assign adj_q = QW'(cq0_reg) - QW'(cq1_reg) - QW'(cq2_reg);

    assign q_data = {x_end && y_end, adj_q, adj_s, sii, ii};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg   <= '0;
            y_reg   <= '0;
            rs_reg  <= '0;
            rq_reg  <= '0;
            c0_reg  <= '0;
            c1_reg  <= '0;
            c2_reg  <= '0;
            cq0_reg <= '0;
            cq1_reg <= '0;
            cq2_reg <= '0;
        end else if (accept) begin
            x_reg  <= x_next;
            y_reg  <= y_next;
            rs_reg <= rs_next;
            rq_reg <= rq_next;
            if (x_first && y_first) begin
                c0_reg  <= CSW'(s_pixel);
                c2_reg  <= CSW'(s_pixel);
                cq0_reg <= CQW'(pp);
                cq2_reg <= CQW'(pp);
            end else if (x_first) begin
                c2_reg  <= c2_reg + CSW'(s_pixel);
                cq2_reg <= cq2_reg + CQW'(pp);
            end
            if (y_first && x_end) begin
                c1_reg  <= CSW'(rs_next);
                cq1_reg <= CQW'(rq_next);
            end
        end
    end

    // line stores: write this column, prefetch the next one
    always_ff @(posedge aclk) begin
        if (accept) begin
            ii_mem[x_reg] <= ii;
            sq_mem[x_reg] <= sii;
            rd_ii_reg     <= ii_mem[x_next];
            rd_sq_reg     <= sq_mem[x_next];
        end
    end

endmodule

// ===== rtl/iiwv_back.sv =====
// ----------------------------------------------------------------------------
// iiwv_back: result back end
// Forwards pixel results to the output register and, for the last pixel of a
// frame, forms N*Q - S*S and, if positive, its integer root one root bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iiwv_back #(
    parameter int WINDOW_WIDTH  = 24,
    parameter int WINDOW_HEIGHT = 24
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_valid,
    output logic                            q_ready,
    input  logic [iiwv_pkg::entry_width(WINDOW_WIDTH, WINDOW_HEIGHT)-1:0] q_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [iiwv_pkg::INTEGRAL_W-1:0]  m_integral,
    output logic [iiwv_pkg::SQUARE_W-1:0]    m_square_integral,
    output logic                            m_deviation_valid,
    output logic [iiwv_pkg::DEVIATION_W-1:0] m_deviation
);
    import iiwv_pkg::*;

    localparam int IW   = integral_width(WINDOW_WIDTH, WINDOW_HEIGHT);
    localparam int QW   = square_width(WINDOW_WIDTH, WINDOW_HEIGHT);
    localparam int N    = (WINDOW_WIDTH - 1) * (WINDOW_HEIGHT - 1);
    localparam int NW   = sum_width(N, 1);
    localparam int SW   = sum_width(N, PIXEL_MAX);
    localparam int QSW  = sum_width(N, SQUARE_MAX);
    localparam int PW   = NW + QSW;
    localparam int SSW  = 2 * SW;
    localparam int DW   = max_width(PW, SSW);
    localparam int RTW  = (DW + 1) / 2;
    localparam int RADW = 2 * RTW;
    localparam int CNTW = max_width(1, $clog2(RTW));
    localparam int RXW  = max_width(RTW, DEVIATION_W);
    localparam logic [NW-1:0] N_CONST = NW'(N);

    back_state_t state_reg, state_next;

    logic                   m_valid_reg;
    logic [INTEGRAL_W-1:0]  m_integral_reg;
    logic [SQUARE_W-1:0]    m_square_reg;
    logic                   m_dev_valid_reg;
    logic [DEVIATION_W-1:0] m_deviation_reg;

    logic [INTEGRAL_W-1:0]  hold_ii_reg;
    logic [SQUARE_W-1:0]    hold_sq_reg;
    logic [SW-1:0]          s_reg;
    logic [QSW-1:0]         q_reg;
    logic [PW-1:0]          nq_reg;
    logic [SSW-1:0]         ss_reg;
    logic [RADW-1:0]        rad_reg;
    logic [RTW+1:0]         rem_reg, rem_next;
    logic [RTW-1:0]         root_reg, root_next;
    logic [CNTW-1:0]        cnt_reg;

    logic [IW-1:0]          e_ii, e_adj_s, sum_s;
    logic [QW-1:0]          e_sii, e_adj_q, sum_q;
    logic                   e_last;
    logic                   out_free, pop, load_pix, load_dev;
    logic [DW-1:0]          nq_x, ss_x, diff;
    logic                   positive;
    logic [RTW+1:0]         rem_sh, trial;
    logic                   take_bit;
    logic [RXW-1:0]         root_x;
    logic [DEVIATION_W-1:0] dev_sat;

    assign e_ii    = q_data[IW-1:0];
    assign e_sii   = q_data[IW+QW-1:IW];
    assign e_adj_s = q_data[2*IW+QW-1:IW+QW];
    assign e_adj_q = q_data[2*IW+2*QW-1:2*IW+QW];
    assign e_last  = q_data[2*IW+2*QW];

    assign out_free = !m_valid_reg || m_ready;
    assign q_ready  = (state_reg == B_TAKE) && out_free;
    assign pop      = q_valid && q_ready;
    assign load_pix = pop && !e_last;
    assign load_dev = (state_reg == B_OUT) && out_free;

    // window sums over the inner rectangle
    assign sum_s = e_ii + e_adj_s;
    assign sum_q = e_sii + e_adj_q;

    assign nq_x     = DW'(nq_reg);
    assign ss_x     = DW'(ss_reg);
    assign positive = nq_x > ss_x;
    assign diff     = nq_x - ss_x;

    // one root bit per cycle, restoring
    assign rem_sh    = {rem_reg[RTW-1:0], rad_reg[RADW-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign take_bit  = rem_sh >= trial;
    assign rem_next  = take_bit ? rem_sh - trial : rem_sh;
    assign root_next = {root_reg[RTW-2:0], take_bit};

    assign root_x  = RXW'(root_reg);
    assign dev_sat = (root_x > RXW'(DEVIATION_MAX)) ? DEVIATION_MAX
                                                     : DEVIATION_W'(root_x);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_TAKE: begin
                if (pop && e_last) begin
                    state_next = B_MUL;
                end
            end
            B_MUL: begin
                state_next = B_DIFF;
            end
            B_DIFF: begin
                state_next = positive ? B_ROOT : B_OUT;
            end
            B_ROOT: begin
                if (cnt_reg == '0) begin
                    state_next = B_OUT;
                end
            end
            B_OUT: begin
                if (out_free) begin
                    state_next = B_TAKE;
                end
            end
            default: begin
                state_next = B_TAKE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_TAKE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_pix || load_dev) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_pix) begin
            m_integral_reg  <= e_ii[INTEGRAL_W-1:0];
            m_square_reg    <= e_sii[SQUARE_W-1:0];
            m_dev_valid_reg <= 1'b0;
            m_deviation_reg <= '0;
        end else if (load_dev) begin
            m_integral_reg  <= hold_ii_reg;
            m_square_reg    <= hold_sq_reg;
            m_dev_valid_reg <= 1'b1;
            m_deviation_reg <= dev_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && e_last) begin
            hold_ii_reg <= e_ii[INTEGRAL_W-1:0];
            hold_sq_reg <= e_sii[SQUARE_W-1:0];
            s_reg       <= SW'(sum_s);
            q_reg       <= QSW'(sum_q);
        end
        if (state_reg == B_MUL) begin
            nq_reg <= PW'(N_CONST) * PW'(q_reg);
            ss_reg <= SSW'(s_reg) * SSW'(s_reg);
        end
        if (state_reg == B_DIFF) begin
            rad_reg  <= RADW'(diff);
            rem_reg  <= '0;
            root_reg <= positive ? '0 : RTW'(DEVIATION_FLAT);
            cnt_reg  <= CNTW'(RTW - 1);
        end else if (state_reg == B_ROOT) begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            cnt_reg  <= cnt_reg - 1'b1;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_integral        = m_integral_reg;
    assign m_square_integral = m_square_reg;
    assign m_deviation_valid = m_dev_valid_reg;
    assign m_deviation       = m_deviation_reg;

`ifndef SYNTHESIS
    a_dev_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_dev_valid_reg |-> m_deviation_reg != '0)
        else $error("frame result carries zero deviation");

    a_pixel_dev_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_dev_valid_reg |-> m_deviation_reg == '0)
        else $error("pixel result carries a deviation");

    a_root_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == B_ROOT && $past(state_reg) != B_ROOT
            |-> $past(state_reg) == B_DIFF)
        else $error("root iteration started without a difference");

    a_last_holds_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && e_last |=> !q_ready)
        else $error("queue popped while the frame result is pending");
`endif

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for integral_image_window_variance_top
// Streams one 24 x 24 frame of pixels and compares every result item, field by
// field, with an in-bench model of the integral, square integral and frame
// deviation. A short table of hand-picked pixels comes first, then the rest of
// the frame in quarters of noise, checkerboard, narrow-range and flat content,
// each with its own idling on both channels, one long output hold-off and one
// drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import iiwv_pkg::*;

    localparam int WIN_W          = 24;
    localparam int WIN_H          = 24;
    localparam int FRAME_PIXELS   = WIN_W * WIN_H;
    localparam int QUARTER_PIXELS = FRAME_PIXELS / 4;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int PRINT_CAP      = 40;

    typedef struct packed {
        logic [INTEGRAL_W-1:0]  integral;
        logic [SQUARE_W-1:0]    square_integral;
        logic                   deviation_valid;
        logic [DEVIATION_W-1:0] deviation;
    } pixel_result_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               typed;
        pixel_result_t      result;
    } stim_row_t;

    typedef enum {FRAME_NOISE, FRAME_FLAT, FRAME_CHECKER, FRAME_NARROW} frame_kind_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic [PIXEL_W-1:0]     s_pixel;
    logic                   m_valid;
    logic                   m_ready;
    logic [INTEGRAL_W-1:0]  m_integral;
    logic [SQUARE_W-1:0]    m_square_integral;
    logic                   m_deviation_valid;
    logic [DEVIATION_W-1:0] m_deviation;

    // model state: position, row sums, per-column line stores, corner sums
    int                    col_pos = 0;
    int                    row_pos = 0;
    logic [12:0]           row_sum = '0;
    logic [20:0]           row_sq_sum = '0;
    logic [INTEGRAL_W-1:0] line_sum [WIN_W];
    logic [SQUARE_W-1:0]   line_sq [WIN_W];
    logic [12:0]           corner_sum [3];
    logic [20:0]           corner_sq [3];

    pixel_result_t pending_results [$];
    stim_row_t     directed_rows [0:21];
    int            mismatch_count = 0;
    int            results_seen = 0;
    int            quiet_cycles = 0;
    int            sender_idle_pct = 0;
    int            receiver_stall_pct = 0;
    int            hold_off_cycles = 0;
    int            frame_pos = 0;

    integral_image_window_variance_top #(
        .WINDOW_WIDTH  (WIN_W),
        .WINDOW_HEIGHT (WIN_H)
    ) u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_pixel           (s_pixel),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_integral        (m_integral),
        .m_square_integral (m_square_integral),
        .m_deviation_valid (m_deviation_valid),
        .m_deviation       (m_deviation)
    );

    always #10 aclk = ~aclk;

    function automatic logic [31:0] square_root_floor(logic [63:0] v);
        logic [31:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = {32'd0, root} | (64'd1 << b);
            if (trial * trial <= v) begin
                root = trial[31:0];
            end
        end
        return root;
    endfunction

    function automatic pixel_result_t integrate_pixel(logic [PIXEL_W-1:0] p);
        logic [15:0]           pp;
        logic [INTEGRAL_W-1:0] ii;
        logic [SQUARE_W-1:0]   sii;
        logic [INTEGRAL_W-1:0] s;
        logic [SQUARE_W-1:0]   q;
        logic [63:0]           nq;
        logic [63:0]           ss;
        logic [31:0]           root;
        pixel_result_t         r;
        pp = p * p;
        if (col_pos == 0) begin
            row_sum    = p;
            row_sq_sum = pp;
        end else begin
            row_sum    = row_sum + p;
            row_sq_sum = row_sq_sum + pp;
        end
        ii  = row_sum;
        sii = row_sq_sum;
        if (row_pos > 0) begin
            ii  = ii + line_sum[col_pos];
            sii = sii + line_sq[col_pos];
        end
        line_sum[col_pos] = ii;
        line_sq[col_pos]  = sii;

        if (col_pos == 0) begin
            if (row_pos == 0) begin
                corner_sum[0] = p;
                corner_sq[0]  = pp;
                corner_sum[2] = p;
                corner_sq[2]  = pp;
            end else begin
                corner_sum[2] = corner_sum[2] + p;
                corner_sq[2]  = corner_sq[2] + pp;
            end
        end
        if (row_pos == 0 && col_pos == WIN_W - 1) begin
            corner_sum[1] = row_sum;
            corner_sq[1]  = row_sq_sum;
        end

        r.integral        = ii;
        r.square_integral = sii;
        r.deviation_valid = 1'b0;
        r.deviation       = '0;
        if (col_pos == WIN_W - 1 && row_pos == WIN_H - 1) begin
            // window excludes row 0 and column 0
            s  = ii + corner_sum[0] - corner_sum[1] - corner_sum[2];
            q  = sii + corner_sq[0] - corner_sq[1] - corner_sq[2];
            nq = 64'(WIN_W - 1) * 64'(WIN_H - 1) * 64'(q);
            ss = 64'(s) * 64'(s);
            r.deviation_valid = 1'b1;
            if (nq > ss) begin
                root = square_root_floor(nq - ss);
                r.deviation = (root > DEVIATION_MAX) ? DEVIATION_MAX : root[DEVIATION_W-1:0];
            end else begin
                r.deviation = DEVIATION_FLAT;
            end
        end

        if (col_pos == WIN_W - 1) begin
            col_pos = 0;
            row_pos = (row_pos == WIN_H - 1) ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
        return r;
    endfunction

    function automatic logic [PIXEL_W-1:0] pick_pixel(frame_kind_t kind,
                                                     logic [PIXEL_W-1:0] level, int pos);
        int x;
        int y;
        x = pos % WIN_W;
        y = pos / WIN_W;
        case (kind)
            FRAME_FLAT:    return level;
            FRAME_CHECKER: return ((x ^ y) & 1) ? 8'd255 : 8'd0;
            FRAME_NARROW:  return level + 8'($urandom_range(3));
            default:       return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic flag_mismatch(string field, longint unsigned got, longint unsigned want);
        if (mismatch_count < PRINT_CAP) begin
            $display("result %0d: %s got %0d want %0d", results_seen, field, got, want);
        end
        mismatch_count++;
    endtask

    // expectation goes in when the item is offered; valid holds until accepted
    task automatic offer_pixel(logic [PIXEL_W-1:0] p, pixel_result_t want);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < sender_idle_pct) gap++;
        pending_results.push_back(want);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= p;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic set_idling(int phase);
        case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 75; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 75; end
            default: begin sender_idle_pct = 15; receiver_stall_pct = 15; end
        endcase
    endtask

    // receiver: random stalls, plus a long hold-off when one is requested
    initial begin
        int hold_len;
        forever begin
            @(posedge aclk);
            if (hold_off_cycles > 0) begin
                hold_len        = hold_off_cycles;
                hold_off_cycles = 0;
                m_ready <= 1'b0;
                repeat (hold_len) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        pixel_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected item, integral", m_integral, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_integral !== want.integral)
                    flag_mismatch("integral", m_integral, want.integral);
                if (m_square_integral !== want.square_integral)
                    flag_mismatch("square_integral", m_square_integral, want.square_integral);
                if (m_deviation_valid !== want.deviation_valid)
                    flag_mismatch("deviation_valid", m_deviation_valid, want.deviation_valid);
                if (m_deviation !== want.deviation)
                    flag_mismatch("deviation", m_deviation, want.deviation);
            end
            results_seen++;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        pixel_result_t want;
        frame_kind_t   kind;
        logic [7:0]    level;
        int            quarter;
        s_valid <= 1'b0;
        s_pixel <= '0;
        m_ready <= 1'b0;
        aresetn <= 1'b0;
        for (int i = 0; i < 3; i++) begin
            corner_sum[i] = '0;
            corner_sq[i]  = '0;
        end

        // row 0 opens: extremes by hand, single bits set and clear, 0x55, 0xAA
        directed_rows = '{
            '{8'd255, 1'b1, '{18'd255, 26'd65025,  1'b0, 17'd0}},
            '{8'd255, 1'b1, '{18'd510, 26'd130050, 1'b0, 17'd0}},
            '{8'd0,   1'b1, '{18'd510, 26'd130050, 1'b0, 17'd0}},
            '{8'd0,   1'b1, '{18'd510, 26'd130050, 1'b0, 17'd0}},
            '{8'd1,   1'b0, '0}, '{8'd2,   1'b0, '0}, '{8'd4,   1'b0, '0},
            '{8'd8,   1'b0, '0}, '{8'd16,  1'b0, '0}, '{8'd32,  1'b0, '0},
            '{8'd64,  1'b0, '0}, '{8'd128, 1'b0, '0}, '{8'd254, 1'b0, '0},
            '{8'd253, 1'b0, '0}, '{8'd251, 1'b0, '0}, '{8'd247, 1'b0, '0},
            '{8'd239, 1'b0, '0}, '{8'd223, 1'b0, '0}, '{8'd191, 1'b0, '0},
            '{8'd127, 1'b0, '0}, '{8'd85,  1'b0, '0}, '{8'd170, 1'b0, '0}
        };

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        set_idling(0);
        foreach (directed_rows[i]) begin
            want = integrate_pixel(directed_rows[i].pixel);
            if (directed_rows[i].typed) want = directed_rows[i].result;
            offer_pixel(directed_rows[i].pixel, want);
            frame_pos++;
        end

        // drain pause: nothing offered until every result is back
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);

        // rest of the frame: content and idling change every quarter
        level = 8'($urandom_range(252));
        do begin
            quarter = frame_pos / QUARTER_PIXELS;
            set_idling(quarter);
            case (quarter)
                0:       kind = FRAME_NOISE;
                1:       kind = FRAME_CHECKER;
                2:       kind = FRAME_NARROW;
                default: kind = FRAME_FLAT;
            endcase
            // long output hold-off while pixels keep coming, so input backs up
            if (frame_pos == 100) hold_off_cycles = HOLD_CYCLES;
            s_pixel_pick: begin
                logic [7:0] p;
                p    = pick_pixel(kind, level, frame_pos);
                want = integrate_pixel(p);
                offer_pixel(p, want);
            end
            frame_pos = (frame_pos + 1) % FRAME_PIXELS;
        end while (frame_pos != 0);

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/iiwv_pkg.sv
rtl/iiwv_queue.sv
rtl/iiwv_front.sv
rtl/iiwv_back.sv
rtl/integral_image_window_variance_top.sv
test/tb.sv
